[src/bpdc_pkg.sv]
// ----------------------------------------------------------------------------
// bpdc_pkg
// Shared types, widths and register codes for the Bezier point evaluator.
// ----------------------------------------------------------------------------
package bpdc_pkg;

  // Field widths
  localparam int T_W         = 17;              // t in Q1.16, 17 bits to hold 1.0
  localparam int FRAC_W      = T_W - 1;         // scale gained per level
  localparam int COORD_W     = 16;
  localparam int NUM_COORDS  = 3;
  localparam int POINT_W     = COORD_W * NUM_COORDS;
  localparam int NUM_PT_REGS = 4;
  localparam int NUM_LEVELS  = NUM_PT_REGS - 1;
  localparam int FINAL_W     = COORD_W + FRAC_W * NUM_LEVELS;
  localparam int DEG_W       = 2;
  localparam int CFG_IDX_W   = 3;

  // Widest multiplicand done in one piece
  localparam int MUL_MAX_W   = 32;

  // Defaults
  localparam int MAX_POINTS_DEF = 4;

  localparam logic [T_W-1:0]     T_ONE      = T_W'(1) << FRAC_W;
  localparam logic [COORD_W-1:0] SIGN_FLIP  = COORD_W'(1) << (COORD_W - 1);
  localparam logic [DEG_W-1:0]   DEG_RESET  = DEG_W'(NUM_LEVELS);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEGREE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_POINT0 = CFG_IDX_W'(1);

  typedef logic [POINT_W-1:0] point_t;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [DEG_W-1:0]                degree;
    point_t [NUM_PT_REGS-1:0]        points;
  } curve_cfg_t;

  // Stage enables of one interpolation level
  typedef struct packed {
    logic mul_en;
    logic add_en;
  } lvl_ctl_t;

  // Round the 2^48-scaled offset value to nearest (ties up), saturate,
  // and return to two's complement.
  function automatic logic [COORD_W-1:0] round_coord(input logic [FINAL_W-1:0] v);
    logic [FINAL_W:0]     s;
    logic [COORD_W:0]     r;
    logic [COORD_W-1:0]   u;
    s = {1'b0, v} + ((FINAL_W + 1)'(1) << (FINAL_W - COORD_W - 1));
    r = s[FINAL_W:FINAL_W-COORD_W];
    u = r[COORD_W] ? {COORD_W{1'b1}} : r[COORD_W-1:0];
    return u ^ SIGN_FLIP;
  endfunction

endpackage

[src/bpdc_cfg.sv]
// ----------------------------------------------------------------------------
// bpdc_cfg
// Degree and control point registers, with the degree capped to one less
// than the number of points kept.
// ----------------------------------------------------------------------------
module bpdc_cfg #(
  parameter int NUM_PTS = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [bpdc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bpdc_pkg::POINT_W-1:0]       cfg_data,
  output bpdc_pkg::curve_cfg_t               cfg
);
  import bpdc_pkg::*;

  localparam int DEG_MAX = NUM_PTS - 1;

  logic [DEG_W-1:0] degree;

  // Degree register
  always_ff @(posedge clk) begin
    if (rst) begin
      degree <= DEG_RESET;
    end else if (cfg_write && cfg_index == REG_DEGREE) begin
      degree <= cfg_data[DEG_W-1:0];
    end
  end

  assign cfg.degree = (degree > DEG_W'(DEG_MAX)) ? DEG_W'(DEG_MAX) : degree;

  // Point registers; slots past NUM_PTS read as zero
  for (genvar i = 0; i < NUM_PT_REGS; i++) begin : g_pt
    if (i < NUM_PTS) begin : g_reg
      point_t pt;
      always_ff @(posedge clk) begin
        if (rst) begin
          pt <= '0;
        end else if (cfg_write && cfg_index == CFG_IDX_W'(REG_POINT0 + i)) begin
          pt <= cfg_data;
        end
      end
      assign cfg.points[i] = pt;
    end else begin : g_none
      assign cfg.points[i] = '0;
    end
  end

endmodule

[src/bpdc_lerp.sv]
// ----------------------------------------------------------------------------
// bpdc_lerp
// One de Casteljau level over N_IN values: q' = q*2^16 + (q_next - q)*t.
// Two register stages: multiply, then add. Wide differences are split
// into two partial products.
// ----------------------------------------------------------------------------
module bpdc_lerp #(
  parameter int N_IN = 4,
  parameter int IN_W = 16
) (
  input  logic                                 clk,
  input  bpdc_pkg::lvl_ctl_t                   ctl,
  input  logic [bpdc_pkg::T_W-1:0]             t,
  input  logic [IN_W-1:0]                      q_in  [N_IN],
  output logic [IN_W+bpdc_pkg::FRAC_W-1:0]     q_out [N_IN-1]
);
  import bpdc_pkg::*;

  localparam int N_OUT = N_IN - 1;
  localparam int DW    = IN_W + 1;          // signed difference
  localparam int SW    = IN_W + FRAC_W + 2; // signed sum
  localparam int OUT_W = IN_W + FRAC_W;

  logic signed [DW-1:0] diff [N_OUT];
  logic signed [SW-1:0] prod [N_OUT];
  logic signed [SW-1:0] sum  [N_OUT];
  logic [IN_W-1:0]      base [N_OUT];
  logic signed [T_W:0]  ts;

  assign ts = signed'({1'b0, t});

  // Neighbor differences
  always_comb begin
    for (int i = 0; i < N_OUT; i++) begin
      diff[i] = signed'({1'b0, q_in[i+1]}) - signed'({1'b0, q_in[i]});
    end
  end

  // Multiply stage: base value travels with its product
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      for (int i = 0; i < N_OUT; i++) begin
        base[i] <= q_in[i];
      end
    end
  end

  if (DW > MUL_MAX_W) begin : g_split
    localparam int LO_W = DW / 2;
    localparam int HI_W = DW - LO_W;

    logic [LO_W+T_W-1:0]      p_lo [N_OUT];
    logic signed [HI_W+T_W:0] p_hi [N_OUT];

    always_ff @(posedge clk) begin
      if (ctl.mul_en) begin
        for (int i = 0; i < N_OUT; i++) begin
          p_lo[i] <= diff[i][LO_W-1:0] * t;
          p_hi[i] <= signed'(diff[i][DW-1:LO_W]) * ts;
        end
      end
    end

    // Recombine partial products
    always_comb begin
      for (int i = 0; i < N_OUT; i++) begin
        prod[i] = (SW'(p_hi[i]) <<< LO_W) + SW'(signed'({1'b0, p_lo[i]}));
      end
    end
  end else begin : g_full
    logic signed [DW+T_W:0] p [N_OUT];

    always_ff @(posedge clk) begin
      if (ctl.mul_en) begin
        for (int i = 0; i < N_OUT; i++) begin
          p[i] <= diff[i] * ts;
        end
      end
    end

    always_comb begin
      for (int i = 0; i < N_OUT; i++) begin
        prod[i] = SW'(p[i]);
      end
    end
  end

  // Add stage; result stays within [0, 2^OUT_W)
  always_comb begin
    for (int i = 0; i < N_OUT; i++) begin
      sum[i] = signed'({2'b00, base[i], FRAC_W'(0)}) + prod[i];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.add_en) begin
      for (int i = 0; i < N_OUT; i++) begin
        q_out[i] <= sum[i][OUT_W-1:0];
      end
    end
  end

endmodule

[src/bezier_point_de_casteljau.sv]
// ----------------------------------------------------------------------------
// bezier_point_de_casteljau
// 3-D Bezier curve point evaluator, de Casteljau interpolation in exact
// fixed point, degree 0 to 3, one point per cycle while out_stall is low.
//
//   Channel | Signals                         | Beat
//   --------+---------------------------------+------------------------------
//   in      | in_valid, in_stall, t_param     | one curve parameter
//   out     | out_valid, out_stall, pos_x/y/z | one rounded curve point
//   cfg     | cfg_write, cfg_index, cfg_data  | one register write
//
// The pipeline is an input register, three levels of multiply + add and an
// output register; one beat is taken every cycle while in_stall is low.
// Lower degrees run the unused leading levels with t forced to zero, so
// the pipeline depth is the same for every degree.
// Reset clears the valid bits and loads the register reset values.
// A stall holds each full stage whose successor is held; bubbles still close up.
// ----------------------------------------------------------------------------
module bezier_point_de_casteljau #(
  parameter int MAX_POINTS = bpdc_pkg::MAX_POINTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // Configuration
  input  logic                               cfg_write,
  input  logic [bpdc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bpdc_pkg::POINT_W-1:0]       cfg_data,
  // Input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [bpdc_pkg::T_W-1:0]           t_param,
  // Output channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [bpdc_pkg::COORD_W-1:0] pos_x,
  output logic signed [bpdc_pkg::COORD_W-1:0] pos_y,
  output logic signed [bpdc_pkg::COORD_W-1:0] pos_z
);
  import bpdc_pkg::*;

  localparam int NUM_PTS = (MAX_POINTS < NUM_PT_REGS) ? MAX_POINTS : NUM_PT_REGS;
  localparam int NSTG    = 2 * NUM_LEVELS + 2;
  localparam int NTP     = 2 * NUM_LEVELS - 1;

  curve_cfg_t        cfg;
  logic [NSTG-1:0]   vld;
  logic [NSTG-1:0]   vld_next;
  logic [NSTG-1:0]   en;
  logic [T_W-1:0]    t_pipe [NTP];
  logic [T_W-1:0]    t_lvl  [NUM_LEVELS];
  lvl_ctl_t          lvl_ctl [NUM_LEVELS];
  logic [COORD_W-1:0] rnd   [NUM_COORDS];

  // Configuration registers
  bpdc_cfg #(
    .NUM_PTS (NUM_PTS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Stage enables: a stage loads when empty or when its successor moves
  always_comb begin
    en[NSTG-1] = !vld[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_comb begin
    vld_next = vld;
    if (en[0]) begin
      vld_next[0] = in_valid;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (en[k]) begin
        vld_next[k] = vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld[NSTG-1];

  // Parameter pipeline; t above one clamps to one
  always_ff @(posedge clk) begin
    if (en[0]) begin
      t_pipe[0] <= t_param[T_W-1] ? T_ONE : t_param;
    end
    for (int k = 1; k < NTP; k++) begin
      if (en[k]) begin
        t_pipe[k] <= t_pipe[k-1];
      end
    end
  end

  // Per-level t and enables; a level is live once degree + level > 3
  for (genvar lv = 0; lv < NUM_LEVELS; lv++) begin : g_lvl
    logic act;
    assign act = ({1'b0, cfg.degree} + (DEG_W + 1)'(lv + 1)) > (DEG_W + 1)'(NUM_LEVELS);
    assign t_lvl[lv]          = act ? t_pipe[2*lv] : '0;
    assign lvl_ctl[lv].mul_en = en[2*lv+1];
    assign lvl_ctl[lv].add_en = en[2*lv+2];
  end

  // Datapath per coordinate
  for (genvar c = 0; c < NUM_COORDS; c++) begin : g_coord
    logic [COORD_W-1:0]            q0 [NUM_PT_REGS];
    logic [COORD_W+FRAC_W-1:0]     q1 [NUM_PT_REGS-1];
    logic [COORD_W+2*FRAC_W-1:0]   q2 [NUM_PT_REGS-2];
    logic [FINAL_W-1:0]            q3 [NUM_PT_REGS-3];

    // Offset to unsigned by flipping the sign bit
    for (genvar i = 0; i < NUM_PT_REGS; i++) begin : g_in
      assign q0[i] = cfg.points[i][c*COORD_W +: COORD_W] ^ SIGN_FLIP;
    end

    bpdc_lerp #(.N_IN(NUM_PT_REGS), .IN_W(COORD_W)) u_l1 (
      .clk (clk), .ctl (lvl_ctl[0]), .t (t_lvl[0]), .q_in (q0), .q_out (q1)
    );

    bpdc_lerp #(.N_IN(NUM_PT_REGS - 1), .IN_W(COORD_W + FRAC_W)) u_l2 (
      .clk (clk), .ctl (lvl_ctl[1]), .t (t_lvl[1]), .q_in (q1), .q_out (q2)
    );

    bpdc_lerp #(.N_IN(NUM_PT_REGS - 2), .IN_W(COORD_W + 2*FRAC_W)) u_l3 (
      .clk (clk), .ctl (lvl_ctl[2]), .t (t_lvl[2]), .q_in (q2), .q_out (q3)
    );

    assign rnd[c] = round_coord(q3[0]);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en[NSTG-1]) begin
      pos_x <= signed'(rnd[0]);
      pos_y <= signed'(rnd[1]);
      pos_z <= signed'(rnd[2]);
    end
  end

endmodule
